// File: rtl/core/cbss_pkg.sv
// ----------------------------------------------------------------------------
// cbss_pkg
// Shared types and constants of the cubic Bezier spline sampler: item
// layouts, command codes, divider handshake and controller states.
// ----------------------------------------------------------------------------
package cbss_pkg;

  // point layout in the coordinate store: position, incoming, outgoing handle
  localparam int WORDS_PER_POINT = 9;
  localparam int WORD_POS        = 0;
  localparam int WORD_IN         = 3;
  localparam int WORD_OUT        = 6;

  // one in Q16.16 and the chord count limits
  localparam logic [16:0] Q_ONE     = 17'h10000;
  localparam logic [8:0]  SPP_MAX   = 9'd256;
  localparam logic [8:0]  SPP_RESET = 9'd16;

  // command codes
  localparam logic [2:0] KIND_ADD      = 3'd0;
  localparam logic [2:0] KIND_REMOVE   = 3'd1;
  localparam logic [2:0] KIND_COMPUTE  = 3'd2;
  localparam logic [2:0] KIND_SAMPLE_T = 3'd3;
  localparam logic [2:0] KIND_SAMPLE_D = 3'd4;

  // shared divider widths
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 32;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [5:0]  point_index;
    logic signed [31:0] param_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] in_handle_x;
    logic signed [31:0] in_handle_y;
    logic signed [31:0] in_handle_z;
    logic signed [31:0] out_handle_x;
    logic signed [31:0] out_handle_y;
    logic signed [31:0] out_handle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic        [31:0] scalar_result;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD,
    ST_RM_RD,
    ST_RM_WR,
    ST_CMP_DIV,
    ST_EV_RD,
    ST_EV_CAP,
    ST_EV_MUL,
    ST_EV_ADD,
    ST_EV_DONE,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_ROOT,
    ST_CHORD,
    ST_DST_RD,
    ST_DST_CHK,
    ST_DST_DIV,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/cbss_ram.sv
// ----------------------------------------------------------------------------
// cbss_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cbss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cbss_div.sv
// ----------------------------------------------------------------------------
// cbss_div
// Shared restoring divider: one quotient bit per cycle, done pulses for one
// cycle and results hold until the next start.
// ----------------------------------------------------------------------------
module cbss_div
  import cbss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNTW = $clog2(DIV_NW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt = {quo_r[DIV_NW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(DIV_NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[DIV_DW-1:0];

endmodule

// File: rtl/core/cubic_bezier_spline_sampler_core.sv
// ----------------------------------------------------------------------------
// cubic_bezier_spline_sampler_core
// Spline point table with add/remove, chord-sum segment lengths, de Casteljau
// sampling at t and sampling at travelled distance, all in Q16.16.
// ----------------------------------------------------------------------------
// Add stores nine words; remove moves the later points down by one point;
// sample at t makes 12 coordinate reads and 18 interpolations through one
// multiplier; distance scans segments, divides, then samples at t; compute
// divides, then per segment of n chords makes n+1 evaluations and n roots.
// One item at a time; busy is high until the result strobe, which the
// receiver cannot stall. Synchronous reset empties the table and lengths.
module cubic_bezier_spline_sampler_core
  import cbss_pkg::*;
#(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int DEPTH = MAX_POINTS * WORDS_PER_POINT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PIW   = $clog2(MAX_POINTS);
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int PW    = CW + 19;
  localparam int MW    = CW + 1;
  localparam int SQW   = 2 * MW + 2;
  localparam int RW    = SQW / 2;
  localparam int REMW  = RW + 4;
  localparam int RCW   = $clog2(RW);
  localparam int ACCW  = (RW + PIW + 10 > 33) ? (RW + PIW + 10) : 33;
  localparam int CVW   = 32 + PIW + 1;

  // clamp wide sums to 32 bits
  function automatic logic [31:0] sat32(input logic [ACCW-1:0] v);
    sat32 = (v > ACCW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // first word of a point
  function automatic logic [AW-1:0] pt_base(input logic [PIW-1:0] pt);
    pt_base = AW'({pt, 3'b000}) + AW'(pt);
  endfunction

  state_t state_r, state_nxt;

  logic [8:0]           spp_r;
  logic [PCW-1:0]       pc_r, pc_nxt;
  logic [PCW-1:0]       fill_r, fill_nxt;
  logic [31:0]          total_r, total_nxt;
  in_item_t             cmd_r, cmd_nxt;
  out_item_t            res_r, res_nxt;
  logic [3:0]           wc_r, wc_nxt;
  logic [AW-1:0]        mv_r, mv_nxt;
  logic [AW-1:0]        mv_end_r, mv_end_nxt;
  logic [PIW-1:0]       seg_r, seg_nxt;
  logic [16:0]          u_r, u_nxt;
  logic [1:0]           ev_c_r, ev_c_nxt;
  logic [1:0]           ev_p_r, ev_p_nxt;
  logic [1:0]           lv_r, lv_nxt;
  logic [1:0]           j_r, j_nxt;
  logic signed [CW-1:0] w_r [4];
  logic signed [CW-1:0] w_nxt [4];
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [CW-1:0] ev_res_r [3];
  logic signed [CW-1:0] ev_res_nxt [3];
  logic signed [CW-1:0] prev_r [3];
  logic signed [CW-1:0] prev_nxt [3];
  logic [8:0]           n_r, n_nxt;
  logic [8:0]           k_r, k_nxt;
  logic                 first_r, first_nxt;
  logic [16:0]          q0_r, q0_nxt;
  logic [8:0]           r0_r, r0_nxt;
  logic [8:0]           rr_r, rr_nxt;
  logic [1:0]           sq_c_r, sq_c_nxt;
  logic [2*MW-1:0]      sq_r, sq_nxt;
  logic [SQW-1:0]       sumsq_r, sumsq_nxt;
  logic [RW-1:0]        root_r, root_nxt;
  logic [REMW-1:0]      rem_r, rem_nxt;
  logic [RCW-1:0]       rt_cnt_r, rt_cnt_nxt;
  logic [ACCW-1:0]      seg_acc_r, seg_acc_nxt;
  logic [ACCW-1:0]      tot_acc_r, tot_acc_nxt;
  logic [CVW-1:0]       cov_r, cov_nxt;

  logic          c_we;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] c_wdata, c_rdata;
  logic          l_we;
  logic [31:0]   l_wdata, l_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // decode helpers
  logic [8:0]           n_clamp;
  logic                 add_full, rm_bad, rm_none, few;
  logic [14:0]          smp_seg_t;
  logic                 smp_last, smp_bad;
  logic                 lerp_end, seg_last, k_last, mv_last, root_last;
  logic [31:0]          len_eff;
  logic signed [CVW:0]  par_s, cov_s, cov_hi_s, par_diff;
  logic                 dst_hit;
  logic signed [CW-1:0] la, lb, pa_sel, pb_sel, w_new;
  logic signed [CW:0]   ldiff, sdiff;
  logic [MW-1:0]        smag;
  logic signed [PW-1:0] sh, sumv;
  logic [REMW-1:0]      rem_sh, cand;
  logic [ACCW-1:0]      sum_w, tot_sum;
  logic [9:0]           rr_t;
  logic                 rr_carry;
  logic signed [31:0]   wd32;
  logic [PIW-1:0]       ev_pt;
  logic [AW-1:0]        ev_off;

  assign n_clamp   = (spp_r == 9'd0) ? 9'd1 : ((spp_r > SPP_MAX) ? SPP_MAX : spp_r);
  assign add_full  = pc_r >= PCW'(MAX_POINTS);
  assign rm_bad    = 32'(in_data.point_index) >= 32'(pc_r);
  assign rm_none   = 32'(in_data.point_index) == 32'(pc_r) - 32'd1;
  assign few       = pc_r < PCW'(2);
  assign smp_seg_t = in_data.param_value[30:16];
  assign smp_last  = (32'(smp_seg_t) == 32'(pc_r) - 32'd1)
                     && (in_data.param_value[15:0] == 16'd0);
  assign smp_bad   = in_data.param_value[31] || few
                     || (!smp_last && (32'(smp_seg_t) + 32'd1 >= 32'(pc_r)));
  assign lerp_end  = j_r == (2'd2 - lv_r);
  assign seg_last  = 32'(seg_r) + 32'd2 >= 32'(pc_r);
  assign k_last    = k_r == n_r - 9'd1;
  assign mv_last   = mv_r + AW'(1) == mv_end_r;
  assign root_last = rt_cnt_r == RCW'(RW - 1);

  // distance window test on the current segment
  assign len_eff  = (PCW'(seg_r) < fill_r) ? l_rdata : 32'd0;
  assign par_s    = (CVW + 1)'(cmd_r.param_value);
  assign cov_s    = signed'({1'b0, cov_r});
  assign cov_hi_s = cov_s + signed'((CVW + 1)'(len_eff));
  assign par_diff = par_s - cov_s;
  assign dst_hit  = (par_s > cov_s) && (par_s < cov_hi_s);

  // interpolation operands
  always_comb begin
    case (j_r)
      2'd1:    begin la = w_r[1]; lb = w_r[2]; end
      2'd2:    begin la = w_r[2]; lb = w_r[3]; end
      default: begin la = w_r[0]; lb = w_r[1]; end
    endcase
  end
  assign ldiff = (CW + 1)'(lb) - (CW + 1)'(la);
  assign sh    = prod_r >>> 16;
  assign sumv  = PW'(la) + sh;
  assign w_new = sumv[CW-1:0];

  // chord component
  always_comb begin
    case (sq_c_r)
      2'd1:    begin pa_sel = prev_r[1]; pb_sel = ev_res_r[1]; end
      2'd2:    begin pa_sel = prev_r[2]; pb_sel = ev_res_r[2]; end
      default: begin pa_sel = prev_r[0]; pb_sel = ev_res_r[0]; end
    endcase
  end
  assign sdiff = (CW + 1)'(pa_sel) - (CW + 1)'(pb_sel);
  assign smag  = sdiff[CW] ? MW'(-sdiff) : MW'(sdiff);

  // root step
  assign rem_sh = {rem_r[REMW-3:0], sumsq_r[SQW-1 -: 2]};
  assign cand   = REMW'({root_r, 2'b01});

  assign sum_w = seg_acc_r + ACCW'(root_r);
  assign tot_sum = tot_acc_r + sum_w;

  // next chord parameter
  assign rr_t     = {1'b0, rr_r} + {1'b0, r0_r};
  assign rr_carry = rr_t >= {1'b0, n_r};

  // coordinate read address for the control points
  always_comb begin
    case (ev_p_r)
      2'd0:    begin ev_pt = seg_r;          ev_off = AW'(WORD_POS) + AW'(ev_c_r); end
      2'd1:    begin ev_pt = seg_r;          ev_off = AW'(WORD_OUT) + AW'(ev_c_r); end
      2'd2:    begin ev_pt = seg_r + 1'b1;   ev_off = AW'(WORD_IN) + AW'(ev_c_r);  end
      default: begin ev_pt = seg_r + 1'b1;   ev_off = AW'(WORD_POS) + AW'(ev_c_r); end
    endcase
  end

  // word to store when adding
  always_comb begin
    case (wc_r)
      4'd0:    wd32 = cmd_r.pos_x;
      4'd1:    wd32 = cmd_r.pos_y;
      4'd2:    wd32 = cmd_r.pos_z;
      4'd3:    wd32 = cmd_r.in_handle_x;
      4'd4:    wd32 = cmd_r.in_handle_y;
      4'd5:    wd32 = cmd_r.in_handle_z;
      4'd6:    wd32 = cmd_r.out_handle_x;
      4'd7:    wd32 = cmd_r.out_handle_y;
      default: wd32 = cmd_r.out_handle_z;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.kind)
            KIND_ADD:      state_nxt = add_full ? ST_DONE : ST_ADD;
            KIND_REMOVE:   state_nxt = (rm_bad || rm_none) ? ST_DONE : ST_RM_RD;
            KIND_COMPUTE:  state_nxt = few ? ST_DONE : ST_CMP_DIV;
            KIND_SAMPLE_T: state_nxt = smp_bad ? ST_DONE : ST_EV_RD;
            KIND_SAMPLE_D: state_nxt = few ? ST_DONE : ST_DST_RD;
            default:       state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD:     if (wc_r == 4'd8) state_nxt = ST_DONE;
      ST_RM_RD:   state_nxt = ST_RM_WR;
      ST_RM_WR:   state_nxt = mv_last ? ST_DONE : ST_RM_RD;
      ST_CMP_DIV: if (div_rsp.done) state_nxt = ST_EV_RD;
      ST_EV_RD:   state_nxt = ST_EV_CAP;
      ST_EV_CAP:  state_nxt = (ev_p_r == 2'd3) ? ST_EV_MUL : ST_EV_RD;
      ST_EV_MUL:  state_nxt = ST_EV_ADD;
      ST_EV_ADD: begin
        if (lerp_end && lv_r == 2'd2) begin
          state_nxt = (ev_c_r == 2'd2) ? ST_EV_DONE : ST_EV_RD;
        end else begin
          state_nxt = ST_EV_MUL;
        end
      end
      ST_EV_DONE: begin
        if (cmd_r.kind == KIND_COMPUTE) begin
          state_nxt = first_r ? ST_EV_RD : ST_SQ_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SQ_MUL:  state_nxt = ST_SQ_ADD;
      ST_SQ_ADD:  state_nxt = (sq_c_r == 2'd2) ? ST_ROOT : ST_SQ_MUL;
      ST_ROOT:    if (root_last) state_nxt = ST_CHORD;
      ST_CHORD:   state_nxt = (k_last && seg_last) ? ST_DONE : ST_EV_RD;
      ST_DST_RD:  state_nxt = ST_DST_CHK;
      ST_DST_CHK: state_nxt = dst_hit ? ST_DST_DIV : (seg_last ? ST_DONE : ST_DST_RD);
      ST_DST_DIV: if (div_rsp.done) state_nxt = ST_EV_RD;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy      = state_r != ST_IDLE;
    out_valid = state_r == ST_DONE;
  end
  assign out_data = res_r;

  // datapath and memory controls
  always_comb begin
    pc_nxt      = pc_r;
    fill_nxt    = fill_r;
    total_nxt   = total_r;
    cmd_nxt     = cmd_r;
    res_nxt     = res_r;
    wc_nxt      = wc_r;
    mv_nxt      = mv_r;
    mv_end_nxt  = mv_end_r;
    seg_nxt     = seg_r;
    u_nxt       = u_r;
    ev_c_nxt    = ev_c_r;
    ev_p_nxt    = ev_p_r;
    lv_nxt      = lv_r;
    j_nxt       = j_r;
    w_nxt       = w_r;
    prod_nxt    = prod_r;
    ev_res_nxt  = ev_res_r;
    prev_nxt    = prev_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    first_nxt   = first_r;
    q0_nxt      = q0_r;
    r0_nxt      = r0_r;
    rr_nxt      = rr_r;
    sq_c_nxt    = sq_c_r;
    sq_nxt      = sq_r;
    sumsq_nxt   = sumsq_r;
    root_nxt    = root_r;
    rem_nxt     = rem_r;
    rt_cnt_nxt  = rt_cnt_r;
    seg_acc_nxt = seg_acc_r;
    tot_acc_nxt = tot_acc_r;
    cov_nxt     = cov_r;
    c_we        = 1'b0;
    c_waddr     = mv_r;
    c_wdata     = c_rdata;
    c_raddr     = pt_base(ev_pt) + ev_off;
    l_we        = 1'b0;
    l_wdata     = sat32(sum_w);
    div_req     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = in_data;
          res_nxt  = '0;
          wc_nxt   = '0;
          ev_c_nxt = '0;
          ev_p_nxt = '0;
          case (in_data.kind)
            KIND_ADD: res_nxt.status = add_full;
            KIND_REMOVE: begin
              res_nxt.status = rm_bad;
              mv_nxt         = pt_base(PIW'(in_data.point_index));
              mv_end_nxt     = pt_base(PIW'(pc_r - 1'b1));
              if (!rm_bad && rm_none) pc_nxt = pc_r - 1'b1;
            end
            KIND_COMPUTE: begin
              n_nxt = n_clamp;
              if (few) begin
                res_nxt.status = 1'b1;
                fill_nxt       = '0;
                total_nxt      = '0;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(Q_ONE);
                div_req.divisor  = DIV_DW'(n_clamp);
              end
            end
            KIND_SAMPLE_T: begin
              res_nxt.status = smp_bad;
              seg_nxt = smp_last ? PIW'(32'(pc_r) - 32'd2) : PIW'(smp_seg_t);
              u_nxt   = smp_last ? Q_ONE : {1'b0, in_data.param_value[15:0]};
            end
            KIND_SAMPLE_D: begin
              res_nxt.status = few;
              seg_nxt        = '0;
              cov_nxt        = '0;
            end
            default: res_nxt.status = 1'b1;
          endcase
        end
      end

      // store the new point, one word a cycle
      ST_ADD: begin
        c_we    = 1'b1;
        c_waddr = pt_base(PIW'(pc_r)) + AW'(wc_r);
        c_wdata = CW'(wd32);
        wc_nxt  = wc_r + 1'b1;
        if (wc_r == 4'd8) begin
          res_nxt.scalar_result = 32'(pc_r);
          pc_nxt                = pc_r + 1'b1;
        end
      end

      // close the gap: move each word down by one point
      ST_RM_RD: c_raddr = mv_r + AW'(WORDS_PER_POINT);
      ST_RM_WR: begin
        c_we    = 1'b1;
        c_waddr = mv_r;
        c_wdata = c_rdata;
        mv_nxt  = mv_r + 1'b1;
        if (mv_last) pc_nxt = pc_r - 1'b1;
      end

      // chord step from the divider, then start the first segment
      ST_CMP_DIV: begin
        if (div_rsp.done) begin
          q0_nxt      = div_rsp.quotient[16:0];
          r0_nxt      = div_rsp.remainder[8:0];
          seg_nxt     = '0;
          tot_acc_nxt = '0;
          seg_acc_nxt = '0;
          k_nxt       = '0;
          u_nxt       = '0;
          rr_nxt      = '0;
          first_nxt   = 1'b1;
          ev_c_nxt    = '0;
          ev_p_nxt    = '0;
        end
      end

      // gather the four control points of one coordinate
      ST_EV_CAP: begin
        case (ev_p_r)
          2'd0:    w_nxt[0] = signed'(c_rdata);
          2'd1:    w_nxt[1] = signed'(c_rdata);
          2'd2:    w_nxt[2] = signed'(c_rdata);
          default: w_nxt[3] = signed'(c_rdata);
        endcase
        ev_p_nxt = ev_p_r + 1'b1;
        lv_nxt   = '0;
        j_nxt    = '0;
      end

      ST_EV_MUL: prod_nxt = PW'(ldiff) * PW'(signed'({1'b0, u_r}));

      // write back one interpolation
      ST_EV_ADD: begin
        case (j_r)
          2'd1:    w_nxt[1] = w_new;
          2'd2:    w_nxt[2] = w_new;
          default: w_nxt[0] = w_new;
        endcase
        if (lerp_end) begin
          j_nxt  = '0;
          lv_nxt = lv_r + 1'b1;
          if (lv_r == 2'd2) begin
            case (ev_c_r)
              2'd0:    ev_res_nxt[0] = w_new;
              2'd1:    ev_res_nxt[1] = w_new;
              default: ev_res_nxt[2] = w_new;
            endcase
            ev_c_nxt = ev_c_r + 1'b1;
            ev_p_nxt = '0;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      ST_EV_DONE: begin
        if (cmd_r.kind == KIND_COMPUTE) begin
          if (first_r) begin
            prev_nxt  = ev_res_r;
            first_nxt = 1'b0;
            rr_nxt    = rr_carry ? 9'(rr_t - {1'b0, n_r}) : rr_t[8:0];
            u_nxt     = u_r + q0_r + 17'(rr_carry);
            ev_c_nxt  = '0;
            ev_p_nxt  = '0;
          end else begin
            sq_c_nxt = '0;
          end
        end else begin
          res_nxt.res_x  = 32'(ev_res_r[0]);
          res_nxt.res_y  = 32'(ev_res_r[1]);
          res_nxt.res_z  = 32'(ev_res_r[2]);
          res_nxt.status = 1'b0;
        end
      end

      // sum of squares for the chord
      ST_SQ_MUL: sq_nxt = (2 * MW)'(smag) * (2 * MW)'(smag);
      ST_SQ_ADD: begin
        sumsq_nxt = ((sq_c_r == 2'd0) ? '0 : sumsq_r) + SQW'(sq_r);
        sq_c_nxt  = sq_c_r + 1'b1;
        root_nxt  = '0;
        rem_nxt   = '0;
        rt_cnt_nxt = '0;
      end

      // integer square root, one bit pair a cycle
      ST_ROOT: begin
        if (rem_sh >= cand) begin
          rem_nxt  = rem_sh - cand;
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        sumsq_nxt  = {sumsq_r[SQW-3:0], 2'b00};
        rt_cnt_nxt = rt_cnt_r + 1'b1;
      end

      // accumulate the chord, close a segment when its chords are done
      ST_CHORD: begin
        prev_nxt = ev_res_r;
        ev_c_nxt = '0;
        ev_p_nxt = '0;
        if (k_last) begin
          l_we        = 1'b1;
          tot_acc_nxt = tot_sum;
          if (seg_last) begin
            total_nxt             = sat32(tot_sum);
            fill_nxt              = pc_r - 1'b1;
            res_nxt.scalar_result = sat32(tot_sum);
          end else begin
            seg_nxt     = seg_r + 1'b1;
            seg_acc_nxt = '0;
            k_nxt       = '0;
            u_nxt       = '0;
            rr_nxt      = '0;
            first_nxt   = 1'b1;
          end
        end else begin
          seg_acc_nxt = sum_w;
          k_nxt       = k_r + 1'b1;
          rr_nxt      = rr_carry ? 9'(rr_t - {1'b0, n_r}) : rr_t[8:0];
          u_nxt       = u_r + q0_r + 17'(rr_carry);
        end
      end

      // walk the length table for the segment holding the distance
      ST_DST_CHK: begin
        if (dst_hit) begin
          div_req.start    = 1'b1;
          div_req.dividend = {par_diff[31:0], 16'h0000};
          div_req.divisor  = len_eff;
        end else begin
          cov_nxt = cov_r + CVW'(len_eff);
          seg_nxt = seg_r + 1'b1;
        end
      end

      ST_DST_DIV: begin
        if (div_rsp.done) begin
          u_nxt    = div_rsp.quotient[16:0];
          ev_c_nxt = '0;
          ev_p_nxt = '0;
        end
      end

      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      spp_r   <= SPP_RESET;
      pc_r    <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) spp_r <= cfg_wdata;
      pc_r    <= pc_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
    wc_r      <= wc_nxt;
    mv_r      <= mv_nxt;
    mv_end_r  <= mv_end_nxt;
    seg_r     <= seg_nxt;
    u_r       <= u_nxt;
    ev_c_r    <= ev_c_nxt;
    ev_p_r    <= ev_p_nxt;
    lv_r      <= lv_nxt;
    j_r       <= j_nxt;
    w_r       <= w_nxt;
    prod_r    <= prod_nxt;
    ev_res_r  <= ev_res_nxt;
    prev_r    <= prev_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    first_r   <= first_nxt;
    q0_r      <= q0_nxt;
    r0_r      <= r0_nxt;
    rr_r      <= rr_nxt;
    sq_c_r    <= sq_c_nxt;
    sq_r      <= sq_nxt;
    sumsq_r   <= sumsq_nxt;
    root_r    <= root_nxt;
    rem_r     <= rem_nxt;
    rt_cnt_r  <= rt_cnt_nxt;
    seg_acc_r <= seg_acc_nxt;
    tot_acc_r <= tot_acc_nxt;
    cov_r     <= cov_nxt;
  end

  cbss_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_coord_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  cbss_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_len_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (seg_r),
    .wdata (l_wdata),
    .raddr (seg_r),
    .rdata (l_rdata)
  );

  cbss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
